// ----- rtl/core/fixed_point_decimal_formatter_assert.svh -----
// Assertion macros for the fixed-point decimal formatter.
`ifndef FIXED_POINT_DECIMAL_FORMATTER_ASSERT_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPDF_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpdf: same-cycle check failed");
`define FPDF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpdf: next-cycle check failed");
`else
`define FPDF_ASSERT_IMPLIES(lbl, ante, cons)
`define FPDF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/fpdf_pkg.sv -----
// Types, constants and helper functions shared by the decimal formatter.
`timescale 1ns / 1ps

package fpdf_pkg;

	localparam int NUM_DIGITS = 5;
	localparam int NUM_CHARS  = 6;
	localparam int BIN_W      = 16;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int WORK_W     = BCD_W + BIN_W;
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_BCD_STAGES = BIN_W / BITS_PER_STAGE;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] LEN_PLAIN = 3'd5;
	localparam logic [2:0] LEN_POINT = 3'd6;
	localparam logic [2:0] DEC_MAX   = 3'd5;

	// register indexes on the config port
	localparam logic CFG_BLANK_ENABLE = 1'b0;
	localparam logic CFG_BLANK_LIMIT  = 1'b1;

	typedef struct packed {
		logic [2:0] dec;   // clamped fraction digit count
		logic       point; // six-character mode with '.'
	} fmt_t;

	// one shift-and-add-3 step on {bcd, binary}
	function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] w);
		logic [WORK_W-1:0] t;
		t = w;
		for (int j = 0; j < NUM_DIGITS; j++) begin
			if (t[BIN_W+4*j +: 4] >= 4'd5) begin
				t[BIN_W+4*j +: 4] = t[BIN_W+4*j +: 4] + 4'd3;
			end
		end
		return {t[WORK_W-2:0], 1'b0};
	endfunction

	function automatic logic [WORK_W-1:0] dabble_group(input logic [WORK_W-1:0] w);
		logic [WORK_W-1:0] t;
		t = w;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			t = dabble_step(t);
		end
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ----- rtl/core/fpdf_bcd_pipe.sv -----
// Pipelined binary to BCD converter, four bits of the value per stage.
`timescale 1ns / 1ps

module fpdf_bcd_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fpdf_pkg::BIN_W-1:0]  in_bin,
	input  fpdf_pkg::fmt_t              in_fmt,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fpdf_pkg::BCD_W-1:0]  out_bcd,
	output fpdf_pkg::fmt_t              out_fmt
);

	localparam int NS = fpdf_pkg::NUM_BCD_STAGES;

	logic                         valid_s [NS];
	logic [fpdf_pkg::WORK_W-1:0]  work_s  [NS];
	fpdf_pkg::fmt_t               fmt_s   [NS];

	logic                         stg_ready [NS];
	logic                         prev_valid [NS];
	logic [fpdf_pkg::WORK_W-1:0]  prev_work  [NS];
	fpdf_pkg::fmt_t               prev_fmt   [NS];

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		stg_ready[NS-1] = !valid_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			stg_ready[k] = !valid_s[k] || stg_ready[k+1];
		end
	end

	always_comb begin
		prev_valid[0] = in_valid;
		prev_work[0]  = {{fpdf_pkg::BCD_W{1'b0}}, in_bin};
		prev_fmt[0]   = in_fmt;
		for (int k = 1; k < NS; k++) begin
			prev_valid[k] = valid_s[k-1];
			prev_work[k]  = work_s[k-1];
			prev_fmt[k]   = fmt_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (stg_ready[k]) begin
					valid_s[k] <= prev_valid[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (stg_ready[k] && prev_valid[k]) begin
				work_s[k] <= fpdf_pkg::dabble_group(prev_work[k]);
				fmt_s[k]  <= prev_fmt[k];
			end
		end
	end

	assign in_ready  = stg_ready[0];
	assign out_valid = valid_s[NS-1];
	assign out_bcd   = work_s[NS-1][fpdf_pkg::WORK_W-1 -: fpdf_pkg::BCD_W];
	assign out_fmt   = fmt_s[NS-1];

endmodule

// ----- rtl/core/fixed_point_decimal_formatter.sv -----
// Top level of the fixed-point decimal formatter: 16-bit value to ASCII text.
`timescale 1ns / 1ps
`include "fixed_point_decimal_formatter_assert.svh"

//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_ready   | value, decimals, with_point
//  out     | out_valid / out_ready | ch0..ch5, text_length
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
//  Six register stages: four binary-to-BCD stages (four value bits each),
//  one stage that lays out digits and '.', one that blanks leading zeros.
//  An item is taken every cycle while out_ready does not stall; out_valid rises when an item
//  has passed stages 1-5 into stage 6. Each stage advances when it is empty or its item moves
//  on, so a stall on out_ready backs up stage by stage and drops or repeats no item.
//  Reset clears the valid bits and both config registers.

module fixed_point_decimal_formatter (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] value,
	input  logic [7:0]  decimals,
	input  logic        with_point,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  ch0,
	output logic [7:0]  ch1,
	output logic [7:0]  ch2,
	output logic [7:0]  ch3,
	output logic [7:0]  ch4,
	output logic [7:0]  ch5,
	output logic [2:0]  text_length
);

	localparam int NC = fpdf_pkg::NUM_CHARS;

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic       blank_enable_q;
	logic [2:0] blank_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_enable_q <= 1'b0;
			blank_limit_q  <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				fpdf_pkg::CFG_BLANK_ENABLE: blank_enable_q <= cfg_data[0];
				fpdf_pkg::CFG_BLANK_LIMIT:  blank_limit_q  <= cfg_data;
				default:                    blank_limit_q  <= blank_limit_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stages 1-4: binary to BCD
	// ------------------------------------------------------------------
	fpdf_pkg::fmt_t               in_fmt;
	logic                         bcd_valid;
	logic                         bcd_ready;
	logic [fpdf_pkg::BCD_W-1:0]   bcd_digits;
	fpdf_pkg::fmt_t               bcd_fmt;

	// clamp the fraction count to five at the door; only three bits travel on
	always_comb begin
		in_fmt.point = with_point;
		if (decimals > 8'(fpdf_pkg::DEC_MAX)) begin
			in_fmt.dec = fpdf_pkg::DEC_MAX;
		end else begin
			in_fmt.dec = decimals[2:0];
		end
	end

	fpdf_bcd_pipe u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_bin    (value),
		.in_fmt    (in_fmt),
		.out_valid (bcd_valid),
		.out_ready (bcd_ready),
		.out_bcd   (bcd_digits),
		.out_fmt   (bcd_fmt)
	);

	// ------------------------------------------------------------------
	// Stage 5: place digits and the point
	// ------------------------------------------------------------------
	logic       valid_s5;
	logic [7:0] chr_s5 [NC];
	logic [2:0] len_s5;
	logic       valid_s6;
	logic [7:0] chr_s6 [NC];
	logic [2:0] len_s6;
	logic       rdy_s5;
	logic       rdy_s6;

	logic [8*NC-1:0] left_row;   // digits ranked from the left, NUL at the end
	logic [8*NC-1:0] right_row;  // NUL first, digits ranked from the right
	logic [7:0]      lay_chr [NC];
	logic [2:0]      dot_pos;

	assign rdy_s6    = !valid_s6 || out_ready;
	assign rdy_s5    = !valid_s5 || rdy_s6;
	assign bcd_ready = rdy_s5;

	always_comb begin
		left_row  = {fpdf_pkg::CH_NUL, fpdf_pkg::CH_NUL, fpdf_pkg::CH_NUL,
		             fpdf_pkg::CH_NUL, fpdf_pkg::CH_NUL, fpdf_pkg::CH_NUL};
		right_row = left_row;
		for (int j = 0; j < fpdf_pkg::NUM_DIGITS; j++) begin
			// digit j counts from the least significant end
			left_row[8*(j+1) +: 8] = {4'h3, bcd_digits[4*j +: 4]};
			right_row[8*j +: 8]    = {4'h3, bcd_digits[4*j +: 4]};
		end
		dot_pos = fpdf_pkg::DEC_MAX - bcd_fmt.dec;
		for (int i = 0; i < NC; i++) begin
			if (!bcd_fmt.point || 3'(i) < dot_pos) begin
				lay_chr[i] = left_row[8*(NC-1-i) +: 8];
			end else if (3'(i) == dot_pos) begin
				lay_chr[i] = fpdf_pkg::CH_DOT;
			end else begin
				lay_chr[i] = right_row[8*(NC-1-i) +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (rdy_s5) begin
			valid_s5 <= bcd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && bcd_valid) begin
			chr_s5 <= lay_chr;
			len_s5 <= bcd_fmt.point ? fpdf_pkg::LEN_POINT : fpdf_pkg::LEN_PLAIN;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: leading-zero blanking into the output register
	// ------------------------------------------------------------------
	logic [2:0] run_len;    // leading '0' count inside the text
	logic       run_on;
	logic       lim_hit;
	logic [2:0] blank_cnt;
	logic       next_dig;
	logic       keep_last;
	logic [7:0] blk_chr [NC];

	always_comb begin
		run_len = 3'd0;
		run_on  = 1'b1;
		for (int i = 0; i < NC; i++) begin
			if (run_on && 3'(i) < len_s5 && chr_s5[i] == fpdf_pkg::CH_ZERO) begin
				run_len = run_len + 3'd1;
			end else begin
				run_on = 1'b0;
			end
		end

		// a nonzero limit cuts the run once that many zeros are counted
		lim_hit   = (blank_limit_q != 3'd0) && (run_len >= blank_limit_q);
		blank_cnt = lim_hit ? blank_limit_q : run_len;

		next_dig = 1'b0;
		for (int i = 0; i < NC; i++) begin
			if (3'(i) == blank_cnt && 3'(i) < len_s5) begin
				next_dig = fpdf_pkg::is_digit(chr_s5[i]);
			end
		end

		// give back the last zero when cut by the limit or followed by '.' or the end
		keep_last = (blank_cnt != 3'd0) && (lim_hit || !next_dig);

		for (int i = 0; i < NC; i++) begin
			if (blank_enable_q && 3'(i) < blank_cnt &&
			    !(keep_last && 3'(i) == blank_cnt - 3'd1)) begin
				blk_chr[i] = fpdf_pkg::CH_SPACE;
			end else begin
				blk_chr[i] = chr_s5[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (rdy_s6) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && valid_s5) begin
			chr_s6 <= blk_chr;
			len_s6 <= len_s5;
		end
	end

	assign out_valid   = valid_s6;
	assign ch0         = chr_s6[0];
	assign ch1         = chr_s6[1];
	assign ch2         = chr_s6[2];
	assign ch3         = chr_s6[3];
	assign ch4         = chr_s6[4];
	assign ch5         = chr_s6[5];
	assign text_length = len_s6;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`FPDF_ASSERT_IMPLIES(a_len_legal, out_valid, text_length == fpdf_pkg::LEN_PLAIN || text_length == fpdf_pkg::LEN_POINT)
	`FPDF_ASSERT_IMPLIES(a_plain_tail_nul, out_valid && text_length == fpdf_pkg::LEN_PLAIN, ch5 == fpdf_pkg::CH_NUL)
	`FPDF_ASSERT_IMPLIES(a_empty_out_takes_item, !valid_s6, in_ready)
	`FPDF_ASSERT_NEXT(a_s5_moves_on, valid_s5 && rdy_s6, valid_s6)

endmodule
